>>> hdl/swb_pkg.sv
package swb_pkg;

	localparam int unsigned TableDepthDef = 256;
	localparam int unsigned WordW = 32;
	localparam int unsigned LagShort = 15;
	localparam int unsigned LagLong = 237;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_GEN  = 1'b1
	} cmd_t;

endpackage

>>> hdl/swb_table.sv
module swb_table import swb_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TableDepthDef,
	localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [IdxW-1:0] wr_addr,
	input  word_t           wr_data,
	input  logic [IdxW-1:0] rd_addr_a,
	input  logic [IdxW-1:0] rd_addr_b,
	output word_t           rd_data_a,
	output word_t           rd_data_b
);

	word_t mem [TABLE_DEPTH];
	word_t rd_a_q;
	word_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// forward a same-cycle write so the prefetched word is never stale
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == rd_addr_a) begin
			rd_a_q <= wr_data;
		end else begin
			rd_a_q <= mem[rd_addr_a];
		end
		if (wr_en && wr_addr == rd_addr_b) begin
			rd_b_q <= wr_data;
		end else begin
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

>>> hdl/swb_step.sv
module swb_step import swb_pkg::*; (
	input  word_t first_word,
	input  word_t second_word,
	input  word_t prev_second,
	output word_t result
);

	logic  borrow;
	word_t sub_term;

	always_comb begin
		borrow   = (first_word < prev_second);
		sub_term = second_word + word_t'(borrow);
		result   = first_word - sub_term;
	end

endmodule

>>> hdl/subtract_with_borrow_rng.sv
// Lagged subtract-with-borrow generator (lags 15 and 237) over a table of
// 32-bit words. A word with cmd low writes load_word into the table at
// load_index and restarts the sequence; it gives no output. A word with cmd
// high yields one random_word the cycle after it is taken, and the block
// takes one word every cycle as long as the output side keeps up. The rate
// is set by the table, which has two read ports and one write port: both
// operands for the next step are read into registers in advance, from
// addresses that follow the position alone, so the step itself is one
// compare, one subtract and one table write. Load every entry before the
// first generate word; unwritten entries give arbitrary values.
module subtract_with_borrow_rng import swb_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TableDepthDef,
	localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            cmd,
	input  logic [IdxW-1:0] load_index,
	input  word_t           load_word,
	output logic            out_valid,
	input  logic            out_stall,
	output word_t           random_word
);

	logic            accept;
	logic            do_gen;
	logic            do_load;
	logic [IdxW-1:0] pos_q;
	logic [IdxW-1:0] pos_next;
	word_t           second_q;
	word_t           rd_first;
	word_t           rd_second;
	word_t           result;
	logic            wr_en;
	logic [IdxW-1:0] wr_addr;
	word_t           wr_data;
	logic            out_valid_q;
	word_t           out_word_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign do_gen   = accept && (cmd == CMD_GEN);
	assign do_load  = accept && (cmd == CMD_LOAD);

	always_comb begin
		priority if (do_load) begin
			pos_next = '0;
		end else if (do_gen) begin
			pos_next = pos_q + IdxW'(1);
		end else begin
			pos_next = pos_q;
		end
	end

	always_comb begin
		wr_en   = do_load || do_gen;
		wr_addr = do_load ? load_index : pos_q + IdxW'(LagLong);
		wr_data = do_load ? load_word : result;
	end

	swb_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (pos_next + IdxW'(LagShort)),
		.rd_addr_b (pos_next + IdxW'(1)),
		.rd_data_a (rd_first),
		.rd_data_b (rd_second)
	);

	swb_step u_step (
		.first_word  (rd_first),
		.second_word (rd_second),
		.prev_second (second_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			second_q <= '0;
		end else begin
			pos_q <= pos_next;
			if (do_load) begin
				second_q <= '0;
			end else if (do_gen) begin
				second_q <= rd_second;
			end
		end
	end

	// hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_gen) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_gen) begin
			out_word_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

`ifndef NO_ASSERTIONS
	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		do_load |=> (pos_q == '0) && (second_q == '0))
		else $error("load did not restart the generator");

	a_gen_advance: assert property (@(posedge clk) disable iff (!arst_n)
		do_gen |=> pos_q == $past(pos_q) + IdxW'(1))
		else $error("generate did not advance the position");

	a_gen_output: assert property (@(posedge clk) disable iff (!arst_n)
		do_gen |=> out_valid && random_word == $past(result))
		else $error("generated word missing at the output");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> pos_q == $past(pos_q) && second_q == $past(second_q))
		else $error("state changed without an accepted word");
`endif

endmodule

>>> tb/subtract_with_borrow_rng_checker.sv
module subtract_with_borrow_rng_checker import swb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] load_index,
	input  word_t      load_word,
	input  logic       out_valid,
	input  logic       out_stall,
	input  word_t      random_word,
	output int         mismatches,
	output int         outstanding,
	output int         matched
);

	word_t      lag_words [TableDepthDef];
	logic [7:0] gen_pos;
	word_t      first_word;
	word_t      second_word;
	word_t      expected_words [$];
	int         fail_total = 0;
	int         pending_total = 0;
	int         match_total = 0;

	assign mismatches = fail_total;
	assign outstanding = pending_total;
	assign matched = match_total;

	task automatic advance_generator(output word_t value);
		logic [7:0] write_at;
		logic [7:0] read_at;
		word_t      borrow;
		write_at = gen_pos + 8'(LagLong);
		read_at = gen_pos + 8'(LagShort);
		first_word = lag_words[read_at];
		borrow = (first_word < second_word) ? word_t'(1) : word_t'(0);
		gen_pos = gen_pos + 8'd1;
		second_word = lag_words[gen_pos];
		value = first_word - (second_word + borrow);
		lag_words[write_at] = value;
	endtask

	always @(posedge clk) begin : watch
		word_t produced;
		word_t wanted;
		if (!arst_n) begin
			gen_pos = '0;
			first_word = '0;
			second_word = '0;
			expected_words.delete();
		end else begin
			if (in_valid && !in_stall) begin
				if (cmd == CMD_LOAD) begin
					lag_words[load_index] = load_word;
					gen_pos = '0;
					first_word = '0;
					second_word = '0;
				end else begin
					advance_generator(produced);
					expected_words.insert(expected_words.size(), produced);
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected random_word %h: no word pending", random_word);
				end else begin
					wanted = expected_words.pop_front();
					if (random_word !== wanted) begin
						fail_total++;
						if (fail_total <= 10)
							$display("random_word mismatch: expected %h, got %h",
								wanted, random_word);
					end else begin
						match_total++;
					end
				end
			end
		end
		pending_total = expected_words.size();
	end

endmodule

>>> tb/subtract_with_borrow_rng_tb.sv
module subtract_with_borrow_rng_tb;
	import swb_pkg::*;

	localparam int ItemTarget = 1100;
	localparam int IdleLimit = 4000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       cmd;
	logic [7:0] load_index;
	word_t      load_word;
	logic       out_valid;
	logic       out_stall;
	word_t      random_word;

	int mismatches;
	int outstanding;
	int matched;

	bit         seeded_entry [TableDepthDef];
	logic [7:0] shadow_pos = '0;
	bit         quiet_run = 1'b0;
	int         loads_sent = 0;
	int         gens_sent = 0;
	int         wraps = 0;
	int         idle_cycles = 0;

	subtract_with_borrow_rng dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.load_index  (load_index),
		.load_word   (load_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

	subtract_with_borrow_rng_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.load_index  (load_index),
		.load_word   (load_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.matched     (matched)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (quiet_run)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_word(cmd_t c, logic [7:0] idx, word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		load_index <= idx;
		load_word <= w;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_load(logic [7:0] idx, word_t w);
		send_word(CMD_LOAD, idx, w);
		seeded_entry[idx] = 1'b1;
		shadow_pos = '0;
		loads_sent++;
	endtask

	// seed any entry this step would read before it was ever written
	task automatic send_gen();
		logic [7:0] far_idx;
		logic [7:0] near_idx;
		logic [7:0] back_idx;
		forever begin
			far_idx = shadow_pos + 8'(LagShort);
			near_idx = shadow_pos + 8'd1;
			if (!seeded_entry[far_idx])
				send_load(far_idx, $urandom());
			else if (!seeded_entry[near_idx])
				send_load(near_idx, $urandom());
			else
				break;
		end
		send_word(CMD_GEN, 8'($urandom()), $urandom());
		back_idx = shadow_pos + 8'(LagLong);
		seeded_entry[back_idx] = 1'b1;
		shadow_pos = shadow_pos + 8'd1;
		if (shadow_pos == 8'd0)
			wraps++;
		gens_sent++;
	endtask

	initial begin : stall_side
		int len;
		int mode;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 9);
			if (mode < 4) begin
				len = $urandom_range(5, 60);
				repeat (len) begin
					@(negedge clk);
					out_stall <= 1'b0;
				end
			end else if (mode < 9) begin
				len = $urandom_range(5, 30);
				repeat (len) begin
					@(negedge clk);
					out_stall <= ($urandom_range(0, 2) == 0);
				end
			end else begin
				len = $urandom_range(20, 50);
				repeat (len) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int run_len;
		int pick;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		load_index = '0;
		load_word = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_load(8'd0, 32'h0000_0000);
		send_load(8'd255, 32'hFFFF_FFFF);
		send_load(8'd15, 32'h0000_0000);
		send_load(8'd1, 32'hFFFF_FFFF);
		send_load(8'd16, 32'h8000_0000);
		send_load(8'd2, 32'h7FFF_FFFF);
		send_load(8'd17, 32'hFFFF_FFFF);
		send_load(8'd3, 32'h0000_0000);
		repeat (4) send_gen();

		while (loads_sent + gens_sent < ItemTarget) begin
			pick = $urandom_range(0, 9);
			quiet_run = ($urandom_range(0, 3) == 0);
			if (pick == 0) begin
				repeat ($urandom_range(1, 3))
					send_load(8'($urandom()), $urandom());
			end else begin
				if ($urandom_range(0, 4) == 0)
					run_len = $urandom_range(256, 300);
				else
					run_len = $urandom_range(1, 40);
				repeat (run_len) begin
					if (loads_sent + gens_sent < ItemTarget)
						send_gen();
				end
			end
		end
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		$display("Drove %0d table loads and %0d generate words; position wrapped %0d times.",
			loads_sent, gens_sent, wraps);
		$display("%0d generated words matched the prediction, %0d mismatches.",
			matched, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> subtract_with_borrow_rng.f
hdl/swb_pkg.sv
hdl/swb_table.sv
hdl/swb_step.sv
hdl/subtract_with_borrow_rng.sv
tb/subtract_with_borrow_rng_checker.sv
tb/subtract_with_borrow_rng_tb.sv
